@@ rtl/ttg_pkg.sv @@
// Shared constants, control structs and the sine table builder for the test tone generator.
package ttg_pkg;

  localparam int unsigned SINE_BITS_DEF = 10;
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  localparam logic [2:0] REG_WAVE   = 3'd0;
  localparam logic [2:0] REG_STEREO = 3'd1;
  localparam logic [2:0] REG_STEP   = 3'd2;
  localparam logic [2:0] REG_SEMI   = 3'd3;
  localparam logic [2:0] REG_GAIN   = 3'd4;
  localparam logic [2:0] REG_FRAMES = 3'd5;

  localparam logic [1:0] WAVE_SINE   = 2'd0;
  localparam logic [1:0] WAVE_SQUARE = 2'd1;
  localparam logic [1:0] WAVE_TRI    = 2'd2;

  localparam logic [1:0]  RST_WAVE   = WAVE_SINE;
  localparam logic        RST_STEREO = 1'b0;
  localparam logic [31:0] RST_STEP   = 32'd5368709;
  localparam logic [14:0] RST_SEMI   = 15'd400;
  localparam logic [15:0] RST_GAIN   = 16'd32768;
  localparam logic [23:0] RST_FRAMES = 24'd8000;

  localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

  typedef struct packed {
    logic [1:0]  wave_type;
    logic        stereo;
    logic [31:0] phase_step;
    logic [14:0] semi_period;
    logic [15:0] gain_q15;
    logic [23:0] frame_count;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic load;
    logic div_step;
    logic gain;
    logic scale;
  } cmd_t;

  typedef struct packed {
    logic is_tri;
    logic div_last;
    logic stereo;
  } sts_t;

  function automatic logic [63:0] mul_shr62(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  function automatic logic [14:0] sine_entry(int unsigned k, int unsigned bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] kk;
    logic [63:0] res;
    kk = 64'(k);
    if (kk == (64'd1 << bits)) begin
      return 15'd32767;
    end
    x = (HALF_PI_Q62 >> bits) * kk
      + (((HALF_PI_Q62 & ((64'd1 << bits) - 64'd1)) * kk) >> bits);
    x2 = mul_shr62(x, x);
    term = x;
    sum = x;
    for (int n = 1; n <= 12; n++) begin
      term = mul_shr62(term, x2) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    res = mul_shr62(sum, 64'd32767);
    return res[14:0];
  endfunction

endpackage

@@ rtl/ttg_regs.sv @@
// Configuration register bank with its write and read port.
module ttg_regs
  import ttg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[ADDR_W-1:2];
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wave_type   <= RST_WAVE;
      cfg_r.stereo      <= RST_STEREO;
      cfg_r.phase_step  <= RST_STEP;
      cfg_r.semi_period <= RST_SEMI;
      cfg_r.gain_q15    <= RST_GAIN;
      cfg_r.frame_count <= RST_FRAMES;
    end else if (wr_en) begin
      unique case (idx)
        REG_WAVE:   cfg_r.wave_type   <= pwdata[1:0];
        REG_STEREO: cfg_r.stereo      <= pwdata[0];
        REG_STEP:   cfg_r.phase_step  <= pwdata;
        REG_SEMI:   cfg_r.semi_period <= pwdata[14:0];
        REG_GAIN:   cfg_r.gain_q15    <= pwdata[15:0];
        REG_FRAMES: cfg_r.frame_count <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_WAVE:   prdata = {30'd0, cfg_r.wave_type};
      REG_STEREO: prdata = {31'd0, cfg_r.stereo};
      REG_STEP:   prdata = cfg_r.phase_step;
      REG_SEMI:   prdata = {17'd0, cfg_r.semi_period};
      REG_GAIN:   prdata = {16'd0, cfg_r.gain_q15};
      REG_FRAMES: prdata = {8'd0, cfg_r.frame_count};
      default:    prdata = '0;
    endcase
  end

endmodule

@@ rtl/ttg_dpath.sv @@
// Datapath: tone state, sine table, serial divider, gain and saturation.
module ttg_dpath
  import ttg_pkg::*;
#(
  parameter int unsigned SINE_TABLE_BITS = SINE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  cmd_t        cmd,
  input  logic        restart,
  output sts_t        sts,
  output logic [15:0] sample,
  output logic        buf_end
);

  localparam int unsigned N = 1 << SINE_TABLE_BITS;
  localparam int unsigned AW = SINE_TABLE_BITS + 1;

  logic [14:0] rom [0:N];
  for (genvar g = 0; g <= N; g++) begin : g_rom
    localparam logic [14:0] ENTRY = sine_entry(g, SINE_TABLE_BITS);
    assign rom[g] = ENTRY;
  end

  logic [31:0] phase_r;
  logic [14:0] off_r;
  logic        odd_r;
  logic [23:0] fd_r;

  logic [31:0] ph_w_r;
  logic [14:0] off_w_r;
  logic        odd_w_r;
  logic        end_r;
  logic [14:0] rom_q_r;
  logic [31:0] num_r;
  logic [15:0] rem_r;
  logic [4:0]  cnt_r;
  logic        dpos_r;
  logic signed [34:0] prod_r;
  logic [15:0] sample_r;

  logic [14:0] s_eff;
  logic [23:0] fc_eff;
  logic [31:0] ph0;
  logic [14:0] off0, off_a;
  logic        odd0, odd_a;
  logic [23:0] fd0;
  logic        end_c;
  logic [15:0] off1;
  logic [SINE_TABLE_BITS-1:0] sidx;
  logic [AW-1:0] addr;
  logic signed [16:0] d;
  logic [14:0] dabs;
  logic [16:0] rem_sh;
  logic signed [17:0] raw;
  logic signed [34:0] adj;
  logic signed [19:0] q;
  logic signed [15:0] g16;
  logic signed [15:0] neg16;

  assign s_eff  = (cfg.semi_period == 15'd0) ? 15'd1 : cfg.semi_period;
  assign fc_eff = (cfg.frame_count == 24'd0) ? 24'd1 : cfg.frame_count;

  always_comb begin
    ph0  = restart ? 32'd0 : phase_r;
    off0 = restart ? 15'd0 : off_r;
    odd0 = restart ? 1'b0 : odd_r;
    fd0  = restart ? 24'd0 : fd_r;
    if (off0 >= s_eff) begin
      off_a = 15'd0;
      odd_a = ~odd0;
    end else begin
      off_a = off0;
      odd_a = odd0;
    end
    end_c = (fd0 >= fc_eff - 24'd1);
    off1  = {1'b0, off_a} + 16'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      off_r   <= '0;
      odd_r   <= 1'b0;
      fd_r    <= '0;
    end else if (cmd.start) begin
      phase_r <= ph0 + cfg.phase_step;
      if (off1 >= {1'b0, s_eff}) begin
        off_r <= 15'd0;
        odd_r <= ~odd_a;
      end else begin
        off_r <= off1[14:0];
        odd_r <= odd_a;
      end
      fd_r <= end_c ? 24'd0 : fd0 + 24'd1;
    end
  end

  assign sidx = ph_w_r[29 -: SINE_TABLE_BITS];
  assign addr = ph_w_r[30] ? AW'(N) - {1'b0, sidx} : {1'b0, sidx};
  assign d    = $signed({2'b00, off_w_r}) - $signed({3'b000, s_eff[14:1]});
  assign dabs = d[16] ? 15'(-d) : d[14:0];
  assign rem_sh = {rem_r, num_r[31]};

  always_comb begin
    if (cfg.wave_type == WAVE_SINE) begin
      raw = ph_w_r[31] ? -$signed({3'b000, rom_q_r}) : $signed({3'b000, rom_q_r});
    end else if (cfg.wave_type == WAVE_SQUARE) begin
      raw = 18'sd32767;
    end else if (cfg.wave_type == WAVE_TRI) begin
      raw = dpos_r ? -$signed({2'b00, num_r[15:0]}) : $signed({2'b00, num_r[15:0]});
    end else begin
      raw = 18'sd0;
    end
  end

  always_comb begin
    adj = prod_r[34] ? prod_r + 35'sd32767 : prod_r;
    q   = 20'(adj >>> 15);
    if (q > 20'sd32767) begin
      g16 = 16'sd32767;
    end else if (q < -20'sd32768) begin
      g16 = -16'sd32768;
    end else begin
      g16 = q[15:0];
    end
    neg16 = (g16 == -16'sd32768) ? 16'sd32767 : -g16;
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      ph_w_r  <= ph0;
      off_w_r <= off_a;
      odd_w_r <= odd_a;
      end_r   <= end_c;
    end
    if (cmd.load) begin
      rom_q_r <= rom[addr];
      num_r   <= ({17'd0, dabs} << 16) - {17'd0, dabs};
      rem_r   <= '0;
      cnt_r   <= '0;
      dpos_r  <= ~d[16] && (d != 17'sd0);
    end
    if (cmd.div_step) begin
      cnt_r <= cnt_r + 5'd1;
      if (rem_sh >= {2'b00, s_eff}) begin
        rem_r <= 16'(rem_sh - {2'b00, s_eff});
        num_r <= {num_r[30:0], 1'b1};
      end else begin
        rem_r <= rem_sh[15:0];
        num_r <= {num_r[30:0], 1'b0};
      end
    end
    if (cmd.gain) begin
      prod_r <= 35'(raw * $signed({1'b0, cfg.gain_q15}));
    end
    if (cmd.scale) begin
      if (odd_w_r && (cfg.wave_type == WAVE_SQUARE || cfg.wave_type == WAVE_TRI)) begin
        sample_r <= neg16;
      end else begin
        sample_r <= g16;
      end
    end
  end

  assign sts.is_tri   = (cfg.wave_type == WAVE_TRI);
  assign sts.div_last = (cnt_r == 5'd31);
  assign sts.stereo   = cfg.stereo;
  assign sample       = sample_r;
  assign buf_end      = end_r;

endmodule

@@ rtl/ttg_ctrl.sv @@
// Controller state machine that sequences one frame through the datapath.
module ttg_ctrl
  import ttg_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output logic out_channel,
  output logic out_frame_last,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_GAIN  = 3'd3;
  localparam logic [2:0] S_SCALE = 3'd4;
  localparam logic [2:0] S_OUT0  = 3'd5;
  localparam logic [2:0] S_OUT1  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       accept;

  assign in_stall       = (state_r != S_IDLE);
  assign accept         = in_valid & ~in_stall;
  assign out_valid      = (state_r == S_OUT0) || (state_r == S_OUT1);
  assign out_channel    = (state_r == S_OUT1);
  assign out_frame_last = (state_r == S_OUT1) || !sts.stereo;

  assign cmd.start    = accept;
  assign cmd.load     = (state_r == S_LOAD);
  assign cmd.div_step = (state_r == S_DIV);
  assign cmd.gain     = (state_r == S_GAIN);
  assign cmd.scale    = (state_r == S_SCALE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = S_LOAD;
      S_LOAD:  state_nxt = sts.is_tri ? S_DIV : S_GAIN;
      S_DIV:   if (sts.div_last) state_nxt = S_GAIN;
      S_GAIN:  state_nxt = S_SCALE;
      S_SCALE: state_nxt = S_OUT0;
      S_OUT0:  if (!out_stall) state_nxt = sts.stereo ? S_OUT1 : S_IDLE;
      S_OUT1:  if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_LOAD) else $error("accepted transaction did not start load");
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input open while result pending");
  a_right_stereo: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT1 |-> sts.stereo) else $error("right sample in mono mode");
  a_mono_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT0 && !out_stall && !sts.stereo) |=> state_r == S_IDLE)
    else $error("mono frame did not finish");
`endif

endmodule

@@ rtl/test_tone_generator.sv @@
// Top level of the test tone generator.
//
// Channel  Direction  Handshake         Payload
// in_      input      valid / stall     restart
// out_     output     valid / stall     sample, channel, frame_last, buffer_end
// cfg      input      APB style         six 32-bit registers at 4*i
//
// A frame runs through the load, gain and scale steps before its samples are delivered;
// a triangle frame also runs the serial divider that forms the ramp value.
// One frame is processed at a time; the input stalls until all results are taken.
// Reset is synchronous, clears the tone state and sets the registers to their defaults.
// A stalled output holds its sample until the transaction completes.
module test_tone_generator
  import ttg_pkg::*;
#(
  parameter int unsigned SINE_TABLE_BITS = SINE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_restart,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [15:0] out_sample,
  output logic              out_channel,
  output logic              out_frame_last,
  output logic              out_buffer_end,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t        cfg;
  cmd_t        cmd;
  sts_t        sts;
  logic [15:0] sample;

  ttg_regs u_regs (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  ttg_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_channel,
    .out_frame_last, .sts, .cmd
  );

  ttg_dpath #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_dpath (
    .clk, .rst_n, .cfg, .cmd, .restart(in_restart), .sts, .sample,
    .buf_end(out_buffer_end)
  );

  assign out_sample = $signed(sample);

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for the test tone generator with its own tone predictor.
module testbench;
  import ttg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TBL_BITS = SINE_BITS_DEF;
  localparam int unsigned TBL_N = 1 << TBL_BITS;
  localparam int unsigned SETTLE = 60;
  localparam longint unsigned CYCLE_LIMIT = 3000000;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct {
    logic signed [15:0] sample;
    logic channel;
    logic frame_last;
    logic buffer_end;
  } tone_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_restart = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_sample;
  logic out_channel;
  logic out_frame_last;
  logic out_buffer_end;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  test_tone_generator uut (.*);

  // Mirror of the block's registers and tone state.
  cfg_t regs;
  logic [31:0] phase_acc;
  logic [14:0] seg_offset;
  logic seg_odd;
  logic [23:0] frames_done;
  int sine_tbl [TBL_N+1];

  tone_result_t pending_samples[$];
  idle_mode_e idle_mode = IDLE_NONE;
  int errors = 0;
  int frames_sent = 0;
  int samples_checked = 0;
  longint unsigned cycles = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [63:0] q62_product(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  function automatic int taylor_sine(int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] acc;
    logic [63:0] kk;
    kk = 64'(k);
    if (k == TBL_N) begin
      return 32767;
    end
    x = (HALF_PI_Q62 >> TBL_BITS) * kk
      + (((HALF_PI_Q62 & 64'(TBL_N - 1)) * kk) >> TBL_BITS);
    x2 = q62_product(x, x);
    term = x;
    acc = x;
    for (int n = 1; n <= 12; n++) begin
      term = q62_product(term, x2) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    return int'(q62_product(acc, 64'd32767));
  endfunction

  function automatic longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint gained(longint raw);
    return clip16((raw * longint'(regs.gain_q15)) / 32768);
  endfunction

  function automatic longint sine_at(logic [31:0] ph);
    logic [1:0] quad;
    int unsigned idx;
    longint v;
    quad = ph[31:30];
    idx = (ph >> (30 - TBL_BITS)) & (TBL_N - 1);
    v = quad[0] ? sine_tbl[TBL_N - idx] : sine_tbl[idx];
    return quad[1] ? -v : v;
  endfunction

  task automatic predict_frame(input logic restart);
    longint s;
    longint fc;
    longint raw;
    longint smp;
    logic last_frame;
    tone_result_t r;
    s = (regs.semi_period == 0) ? 1 : longint'(regs.semi_period);
    fc = (regs.frame_count == 0) ? 1 : longint'(regs.frame_count);
    if (restart) begin
      phase_acc = '0;
      seg_offset = '0;
      seg_odd = 1'b0;
      frames_done = '0;
    end
    if (longint'(seg_offset) >= s) begin
      seg_offset = '0;
      seg_odd = ~seg_odd;
    end
    smp = 0;
    if (regs.wave_type == WAVE_SINE) begin
      smp = gained(sine_at(phase_acc));
    end else if (regs.wave_type == WAVE_SQUARE || regs.wave_type == WAVE_TRI) begin
      raw = 32767;
      if (regs.wave_type == WAVE_TRI) begin
        raw = (-65535 * (longint'(seg_offset) - s / 2)) / s;
      end
      smp = gained(raw);
      if (seg_odd) smp = clip16(-smp);
    end
    last_frame = (longint'(frames_done) >= fc - 1);
    phase_acc = phase_acc + regs.phase_step;
    seg_offset = seg_offset + 15'd1;
    if (longint'(seg_offset) >= s) begin
      seg_offset = '0;
      seg_odd = ~seg_odd;
    end
    frames_done = last_frame ? 24'd0 : frames_done + 24'd1;
    r.sample = smp[15:0];
    r.channel = 1'b0;
    r.frame_last = ~regs.stereo;
    r.buffer_end = last_frame;
    pending_samples.push_back(r);
    if (regs.stereo) begin
      r.channel = 1'b1;
      r.frame_last = 1'b1;
      pending_samples.push_back(r);
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_WAVE:   regs.wave_type = value[1:0];
      REG_STEREO: regs.stereo = value[0];
      REG_STEP:   regs.phase_step = value;
      REG_SEMI:   regs.semi_period = value[14:0];
      REG_GAIN:   regs.gain_q15 = value[15:0];
      REG_FRAMES: regs.frame_count = value[23:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic send_frame(input logic restart);
    in_valid <= 1'b1;
    in_restart <= restart;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    predict_frame(restart);
    frames_sent++;
    if (idle_mode == IDLE_SEND || idle_mode == IDLE_BOTH) begin
      if ($urandom_range(99) < ((idle_mode == IDLE_SEND) ? 84 : 21)) begin
        in_valid <= 1'b0;
        in_restart <= $urandom_range(1);
        do @(posedge clk);
        while ($urandom_range(99) < ((idle_mode == IDLE_SEND) ? 84 : 21));
      end
    end
  endtask

  task automatic random_settings();
    int pick;
    write_reg(REG_WAVE, ($urandom_range(9) == 0) ? 32'(WAVE_TRI + 2'd1) : $urandom_range(2));
    write_reg(REG_STEREO, $urandom);
    pick = $urandom_range(5);
    write_reg(REG_STEP, (pick == 0) ? 32'h8000_0000 : (pick == 1) ? 32'd0 : $urandom);
    write_reg(REG_SEMI, ($urandom_range(7) == 0) ? $urandom : $urandom_range(12));
    pick = $urandom_range(5);
    write_reg(REG_GAIN, (pick == 0) ? 32'd32768 : (pick == 1) ? 32'hFFFF : $urandom);
    write_reg(REG_FRAMES, ($urandom_range(7) == 0) ? $urandom : $urandom_range(9));
  endtask

  task automatic test_reset_defaults();
    for (int i = 0; i < 4; i++) send_frame(1'b0);
    drain();
  endtask

  task automatic test_directed();
    write_reg(REG_WAVE, 32'(WAVE_SQUARE));
    write_reg(REG_STEREO, 32'd1);
    write_reg(REG_SEMI, 32'd1);
    write_reg(REG_GAIN, 32'hFFFF);
    write_reg(REG_FRAMES, 32'd3);
    for (int i = 0; i < 4; i++) send_frame(1'b0);
    drain();
    write_reg(REG_WAVE, 32'(WAVE_TRI));
    write_reg(REG_STEREO, 32'd0);
    write_reg(REG_SEMI, 32'h7FFF);
    write_reg(REG_GAIN, 32'd0);
    write_reg(REG_FRAMES, 32'hFFFF_FFFF);
    send_frame(1'b1);
    drain();
    write_reg(REG_GAIN, 32'd32768);
    write_reg(REG_SEMI, 32'd0);
    write_reg(REG_FRAMES, 32'd0);
    for (int i = 0; i < 3; i++) send_frame(1'b0);
    drain();
    write_reg(REG_SEMI, 32'd50);
    for (int i = 0; i < 6; i++) send_frame(i == 0);
    drain();
    // Lowering the semi period below the current offset ends the segment early.
    write_reg(REG_SEMI, 32'd3);
    send_frame(1'b0);
    send_frame(1'b0);
    drain();
    write_reg(REG_WAVE, 32'd3);
    send_frame(1'b0);
    drain();
    write_reg(REG_WAVE, 32'(WAVE_SINE));
    write_reg(REG_STEP, 32'h8000_0000);
    write_reg(REG_GAIN, 32'hFFFF);
    for (int i = 0; i < 3; i++) send_frame(1'b0);
    drain();
    write_reg(REG_STEP, 32'hFFFF_FFFF);
    send_frame(1'b1);
    send_frame(1'b0);
    drain();
  endtask

  task automatic test_random_traffic(input idle_mode_e mode, input int frames);
    idle_mode = mode;
    for (int i = 0; i < frames; i++) begin
      if (i % 50 == 0) begin
        drain();
        random_settings();
      end
      send_frame($urandom_range(19) == 0);
    end
    drain();
    idle_mode = IDLE_NONE;
  endtask

  task automatic test_backpressure();
    random_settings();
    hold_req = 1'b1;
    for (int i = 0; i < 20; i++) send_frame($urandom_range(9) == 0);
    drain();
  endtask

  always @(posedge clk) begin
    if (hold_req) begin
      hold_req <= 1'b0;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (idle_mode == IDLE_RECV) begin
      out_stall <= ($urandom_range(99) < 84);
    end else if (idle_mode == IDLE_BOTH) begin
      out_stall <= ($urandom_range(99) < 21);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(negedge clk) begin
    tone_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_samples.size() == 0) begin
        $error("unexpected transaction: sample %0d channel %0b", out_sample, out_channel);
        errors++;
      end else begin
        want = pending_samples.pop_front();
        samples_checked++;
        if (out_sample !== want.sample) begin
          $error("sample: expected %0d, got %0d", want.sample, out_sample);
          errors++;
        end
        if (out_channel !== want.channel) begin
          $error("channel: expected %0b, got %0b", want.channel, out_channel);
          errors++;
        end
        if (out_frame_last !== want.frame_last) begin
          $error("frame_last: expected %0b, got %0b", want.frame_last, out_frame_last);
          errors++;
        end
        if (out_buffer_end !== want.buffer_end) begin
          $error("buffer_end: expected %0b, got %0b", want.buffer_end, out_buffer_end);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    for (int k = 0; k <= TBL_N; k++) sine_tbl[k] = taylor_sine(k);
    regs.wave_type = RST_WAVE;
    regs.stereo = RST_STEREO;
    regs.phase_step = RST_STEP;
    regs.semi_period = RST_SEMI;
    regs.gain_q15 = RST_GAIN;
    regs.frame_count = RST_FRAMES;
    phase_acc = '0;
    seg_offset = '0;
    seg_odd = 1'b0;
    frames_done = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_directed();
    test_random_traffic(IDLE_NONE, 300);
    test_random_traffic(IDLE_SEND, 300);
    test_random_traffic(IDLE_RECV, 300);
    test_random_traffic(IDLE_BOTH, 300);
    test_backpressure();
    drain();
    $display("Sent %0d frames and checked %0d samples over sine, square, triangle",
             frames_sent, samples_checked);
    $display("and undefined waves, mono and stereo, with idle, stall and hold-off phases.");
    if (errors == 0 && pending_samples.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/ttg_pkg.sv
rtl/ttg_regs.sv
rtl/ttg_dpath.sv
rtl/ttg_ctrl.sv
rtl/test_tone_generator.sv
bench/testbench.sv
